// ----- rtl/ulam_spiral_prime_walker_defines.svh -----
// Assertion macros for the Ulam spiral prime walker.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef ULAM_SPIRAL_PRIME_WALKER_DEFINES_SVH
`define ULAM_SPIRAL_PRIME_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define USP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usp assertion failed");
`define USP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usp assertion failed");
`else
`define USP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define USP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/usp_pkg.sv -----
// Package for the Ulam spiral prime walker: widths, codes and shared types.
// No dependencies; used by usp_prime and ulam_spiral_prime_walker.
package usp_pkg;

    localparam int COORD_BITS    = 11;
    localparam int NUMBER_BITS   = 21;
    localparam int LIMIT_BITS    = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CMP_BITS      = ((COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS) + 1;
    localparam int DIV_BITS      = NUMBER_BITS / 2 + 2;
    localparam int SQ_BITS       = 2 * DIV_BITS;
    localparam int RADIX         = 3;
    localparam int ITERS         = (NUMBER_BITS + RADIX - 1) / RADIX;
    localparam int DIVIDEND_BITS = ITERS * RADIX;
    localparam int CNT_BITS      = $clog2(ITERS);

    localparam logic [CFG_IDX_BITS-1:0] REG_X_LIMIT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_LIMIT = CFG_IDX_BITS'(1);
    localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET = LIMIT_BITS'(150);

    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_UP    = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_DOWN  = 2'd3;

    typedef struct packed {
        logic                   start;
        logic [NUMBER_BITS-1:0] number;
    } t_prime_req;

    typedef struct packed {
        logic done;
        logic is_prime;
    } t_prime_rsp;

endpackage

// ----- rtl/usp_prime.sv -----
// Trial-division primality checker: one shared square/remainder datapath
// stepped by a small sequencer, three quotient bits per cycle. Uses usp_pkg.
`include "ulam_spiral_prime_walker_defines.svh"
module usp_prime (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  usp_pkg::t_prime_req i_req,
    output usp_pkg::t_prime_rsp o_rsp
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_SQ   = 3'd1;
    localparam logic [2:0] P_CMP  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_TEST = 3'd4;

    logic [2:0]                      r_state, n_state;
    logic [usp_pkg::NUMBER_BITS-1:0]   r_n, n_n;
    logic [usp_pkg::DIV_BITS-1:0]      r_d, n_d;
    logic [usp_pkg::SQ_BITS-1:0]       r_sq, n_sq;
    logic [usp_pkg::DIV_BITS-1:0]      r_rem, n_rem;
    logic [usp_pkg::DIVIDEND_BITS-1:0] r_shift, n_shift;
    logic [usp_pkg::CNT_BITS-1:0]      r_cnt, n_cnt;
    logic                            r_done, n_done;
    logic                            r_prime, n_prime;

    logic [usp_pkg::DIV_BITS-1:0]      w_rem;
    logic [usp_pkg::DIVIDEND_BITS-1:0] w_shift;

    // remainder step: RADIX restoring subtract stages
    always_comb begin
        logic [usp_pkg::DIV_BITS:0] t;
        w_rem   = r_rem;
        w_shift = r_shift;
        t       = '0;
        for (int k = 0; k < usp_pkg::RADIX; k++) begin
            t = {w_rem, w_shift[usp_pkg::DIVIDEND_BITS-1]};
            if (t >= {1'b0, r_d}) begin
                t = t - {1'b0, r_d};
            end
            w_rem   = t[usp_pkg::DIV_BITS-1:0];
            w_shift = {w_shift[usp_pkg::DIVIDEND_BITS-2:0], 1'b0};
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_d     = r_d;
        n_sq    = r_sq;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_prime = r_prime;
        case (r_state)
            P_IDLE: begin
                n_d = usp_pkg::DIV_BITS'(2);
                if (i_req.start) begin
                    n_n = i_req.number;
                    if (i_req.number < usp_pkg::NUMBER_BITS'(2)) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                    end else begin
                        n_state = P_SQ;
                    end
                end
            end
            P_SQ: begin
                n_sq    = usp_pkg::SQ_BITS'(r_d) * usp_pkg::SQ_BITS'(r_d);
                n_state = P_CMP;
            end
            P_CMP: begin
                if (r_sq > usp_pkg::SQ_BITS'(r_n)) begin
                    n_done  = 1'b1;
                    n_prime = 1'b1;
                    n_state = P_IDLE;
                end else begin
                    n_rem   = '0;
                    n_shift = usp_pkg::DIVIDEND_BITS'(r_n);
                    n_cnt   = '0;
                    n_state = P_DIV;
                end
            end
            P_DIV: begin
                n_rem   = w_rem;
                n_shift = w_shift;
                n_cnt   = r_cnt + usp_pkg::CNT_BITS'(1);
                if (r_cnt == usp_pkg::CNT_BITS'(usp_pkg::ITERS - 1)) begin
                    n_state = P_TEST;
                end
            end
            P_TEST: begin
                if (r_rem == '0) begin
                    n_done  = 1'b1;
                    n_prime = 1'b0;
                    n_state = P_IDLE;
                end else begin
                    n_d     = r_d + usp_pkg::DIV_BITS'(1);
                    n_state = P_SQ;
                end
            end
            default: begin
                n_state = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
            r_d     <= usp_pkg::DIV_BITS'(2);
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_d     <= n_d;
        end
        r_n     <= n_n;
        r_sq    <= n_sq;
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_cnt   <= n_cnt;
        r_prime <= n_prime;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.is_prime = r_prime;

    `USP_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, r_done, r_state == P_IDLE)
    `USP_ASSERT_IMPLY(a_rem_below_div, i_clk, i_rst_n, r_state == P_DIV, r_rem < r_d)
    `USP_ASSERT_IMPLY(a_div_min, i_clk, i_rst_n, r_state != P_IDLE, r_d >= usp_pkg::DIV_BITS'(2))

endmodule

// ----- rtl/ulam_spiral_prime_walker.sv -----
// Flow: an accepted cell waits in a busy state while usp_prime runs square, compare,
// remainder and test for each divisor; a cell numbered 0 or 1 answers at once. A
// finished-walk item skips the busy state. From the finish state the beat is registered
// into the output register once that register is free.
// Throughput: one item at a time; the next item is taken while a result beat waits.
// Reset (synchronous, active low): walk back at number 1, limits at 150, idle.
`include "ulam_spiral_prime_walker_defines.svh"
module ulam_spiral_prime_walker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [usp_pkg::COORD_BITS-1:0] o_cell_x,
    output logic signed [usp_pkg::COORD_BITS-1:0] o_cell_y,
    output logic [usp_pkg::NUMBER_BITS-1:0]     o_cell_number,
    output logic                                o_is_prime,
    output logic                                o_finished,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [usp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [usp_pkg::LIMIT_BITS-1:0]      i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                      r_state;
    logic [usp_pkg::LIMIT_BITS-1:0]  r_x_limit, r_y_limit;
    logic [usp_pkg::COORD_BITS-1:0]  r_pos_x, r_pos_y, r_leg, r_steps;
    logic [1:0]                      r_heading;
    logic [usp_pkg::NUMBER_BITS-1:0] r_next_num;
    logic                            r_walk_done;

    logic [usp_pkg::COORD_BITS-1:0]  r_cell_x, r_cell_y;
    logic [usp_pkg::NUMBER_BITS-1:0] r_cell_num;
    logic                            r_cell_prime, r_cell_fin;

    logic                            r_out_valid;
    logic [usp_pkg::COORD_BITS-1:0]  r_out_x, r_out_y;
    logic [usp_pkg::NUMBER_BITS-1:0] r_out_num;
    logic                            r_out_prime, r_out_fin;

    logic [usp_pkg::COORD_BITS-1:0]  w_x, w_y, w_leg, w_steps;
    logic [1:0]                      w_head;
    logic [usp_pkg::NUMBER_BITS-1:0] w_num;
    logic                            w_done;

    logic                            in_acc, out_acc, out_free;
    usp_pkg::t_prime_req             prime_req;
    usp_pkg::t_prime_rsp             prime_rsp;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // walk step for one beat
    always_comb begin
        logic                                 horiz, origin;
        logic signed [usp_pkg::CMP_BITS-1:0]  c, lim;
        w_x    = i_restart ? '0 : r_pos_x;
        w_y    = i_restart ? '0 : r_pos_y;
        w_head = i_restart ? usp_pkg::HEAD_RIGHT : r_heading;
        w_leg  = i_restart ? '0 : r_leg;
        w_steps = i_restart ? '0 : r_steps;
        w_num  = i_restart ? usp_pkg::NUMBER_BITS'(1) : r_next_num;
        w_done = i_restart ? 1'b0 : r_walk_done;
        origin = 1'b0;
        horiz  = ~w_head[0];
        c      = usp_pkg::CMP_BITS'($signed(horiz ? w_x : w_y));
        lim    = $signed(usp_pkg::CMP_BITS'(horiz ? r_x_limit : r_y_limit));
        if (!w_done && w_steps == '0) begin
            if (c >= lim) begin
                w_done = 1'b1;
            end else begin
                origin = (w_leg == '0);
                if (horiz && w_leg != '1) begin
                    w_leg = w_leg + usp_pkg::COORD_BITS'(1);
                end
                w_steps = w_leg;
            end
        end
        if (!w_done && !origin) begin
            case (w_head)
                usp_pkg::HEAD_RIGHT: w_x = w_x + usp_pkg::COORD_BITS'(1);
                usp_pkg::HEAD_UP:    w_y = w_y + usp_pkg::COORD_BITS'(1);
                usp_pkg::HEAD_LEFT:  w_x = w_x - usp_pkg::COORD_BITS'(1);
                default:             w_y = w_y - usp_pkg::COORD_BITS'(1);
            endcase
            w_steps = w_steps - usp_pkg::COORD_BITS'(1);
            if (w_steps == '0) begin
                w_head = w_head + 2'd1;
            end
        end
    end

    assign prime_req.start  = in_acc && !w_done;
    assign prime_req.number = w_num;

    usp_prime u_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (prime_req),
        .o_rsp   (prime_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x_limit   <= usp_pkg::LIMIT_RESET;
            r_y_limit   <= usp_pkg::LIMIT_RESET;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= usp_pkg::HEAD_RIGHT;
            r_leg       <= '0;
            r_steps     <= '0;
            r_next_num  <= usp_pkg::NUMBER_BITS'(1);
            r_walk_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == usp_pkg::REG_X_LIMIT) begin
                    r_x_limit <= i_cfg_data;
                end else if (i_cfg_index == usp_pkg::REG_Y_LIMIT) begin
                    r_y_limit <= i_cfg_data;
                end
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pos_x     <= w_x;
                        r_pos_y     <= w_y;
                        r_heading   <= w_head;
                        r_leg       <= w_leg;
                        r_steps     <= w_steps;
                        r_walk_done <= w_done;
                        r_next_num  <= w_done ? w_num : w_num + usp_pkg::NUMBER_BITS'(1);
                        r_state     <= w_done ? S_FIN : S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (prime_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (r_state == S_IDLE && in_acc) begin
            r_cell_x     <= w_done ? '0 : w_x;
            r_cell_y     <= w_done ? '0 : w_y;
            r_cell_num   <= w_done ? '0 : w_num;
            r_cell_fin   <= w_done;
            r_cell_prime <= 1'b0;
        end else if (r_state == S_BUSY && prime_rsp.done) begin
            r_cell_prime <= prime_rsp.is_prime;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_x     <= r_cell_x;
            r_out_y     <= r_cell_y;
            r_out_num   <= r_cell_num;
            r_out_prime <= r_cell_prime;
            r_out_fin   <= r_cell_fin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_x      = $signed(r_out_x);
    assign o_cell_y      = $signed(r_out_y);
    assign o_cell_number = r_out_num;
    assign o_is_prime    = r_out_prime;
    assign o_finished    = r_out_fin;

    `USP_ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    `USP_ASSERT_IMPLY(a_rsp_in_busy, i_clk, i_rst_n, prime_rsp.done, r_state == S_BUSY)
    `USP_ASSERT_IMPLY(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FIN)

endmodule

// ----- bench/tb_ulam_spiral_prime_walker.sv -----
// Self-checking bench for ulam_spiral_prime_walker: directed table, then random walks.
// Expected cells come from an in-bench spiral walk with trial-division primality.
// Depends on usp_pkg and the ulam_spiral_prime_walker RTL.
module tb_ulam_spiral_prime_walker;

    localparam int STALL_LIMIT  = 20000;
    localparam int IDLE_PAUSE   = 16;
    localparam int RANDOM_ITEMS = 114;
    localparam int REPORT_MAX   = 10;

    localparam logic [usp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_2 = usp_pkg::CFG_IDX_BITS'(2);
    localparam logic [usp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_3 = usp_pkg::CFG_IDX_BITS'(3);

    typedef struct packed {
        logic signed [usp_pkg::COORD_BITS-1:0] x;
        logic signed [usp_pkg::COORD_BITS-1:0] y;
        logic [usp_pkg::NUMBER_BITS-1:0]       number;
        logic                                  prime;
        logic                                  finished;
    } t_cell_beat;

    typedef enum {ROW_CELL, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                        kind;
        logic [usp_pkg::CFG_IDX_BITS-1:0] index;
        logic [usp_pkg::LIMIT_BITS-1:0]   data;
        logic                             restart;
        bit                               typed;
        t_cell_beat                       beat;
    } t_plan_row;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  i_restart = 1'b0;
    logic                                  i_out_stall = 1'b0;
    logic                                  i_cfg_valid = 1'b0;
    logic [usp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index = '0;
    logic [usp_pkg::LIMIT_BITS-1:0]        i_cfg_data = '0;
    logic                                  o_in_stall;
    logic                                  o_out_valid;
    logic signed [usp_pkg::COORD_BITS-1:0] o_cell_x;
    logic signed [usp_pkg::COORD_BITS-1:0] o_cell_y;
    logic [usp_pkg::NUMBER_BITS-1:0]       o_cell_number;
    logic                                  o_is_prime;
    logic                                  o_finished;
    logic                                  o_cfg_ready;

    ulam_spiral_prime_walker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_x      (o_cell_x),
        .o_cell_y      (o_cell_y),
        .o_cell_number (o_cell_number),
        .o_is_prime    (o_is_prime),
        .o_finished    (o_finished),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // spiral walk state, mirrors the block
    logic signed [usp_pkg::COORD_BITS-1:0] walk_x = '0;
    logic signed [usp_pkg::COORD_BITS-1:0] walk_y = '0;
    logic [1:0]                            walk_dir = usp_pkg::HEAD_RIGHT;
    logic [usp_pkg::COORD_BITS-1:0]        leg_len = '0;
    logic [usp_pkg::COORD_BITS-1:0]        steps_rem = '0;
    logic [usp_pkg::NUMBER_BITS-1:0]       number_next = usp_pkg::NUMBER_BITS'(1);
    logic                                  walk_ended = 1'b0;
    logic [usp_pkg::LIMIT_BITS-1:0]        lim_x = usp_pkg::LIMIT_RESET;
    logic [usp_pkg::LIMIT_BITS-1:0]        lim_y = usp_pkg::LIMIT_RESET;

    t_cell_beat pending_cells[$];
    t_plan_row  plan[$];
    int         mismatches = 0;
    int         burst_left = 0;
    int         quiet_cycles = 0;
    logic [5:0] stall_tick = '0;
    int         stall_mode = 0;

    function automatic bit trial_prime(input logic [usp_pkg::NUMBER_BITS-1:0] n);
        int v;
        v = int'(n);
        if (v < 2) return 1'b0;
        for (int d = 2; d * d <= v; d++)
            if (v % d == 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_cell_beat spiral_next_cell(input logic restart);
        t_cell_beat beat;
        logic       horiz;
        logic       origin;
        int         pos;
        int         lim;
        beat = '0;
        origin = 1'b0;
        if (restart) begin
            walk_x = '0;
            walk_y = '0;
            walk_dir = usp_pkg::HEAD_RIGHT;
            leg_len = '0;
            steps_rem = '0;
            number_next = usp_pkg::NUMBER_BITS'(1);
            walk_ended = 1'b0;
        end
        if (!walk_ended && steps_rem == '0) begin
            horiz = !walk_dir[0];
            pos = int'(horiz ? walk_x : walk_y);
            lim = int'(horiz ? lim_x : lim_y);
            if (pos >= lim) begin
                walk_ended = 1'b1;
            end else begin
                origin = (leg_len == '0);
                if (horiz && leg_len != '1) leg_len = leg_len + usp_pkg::COORD_BITS'(1);
                steps_rem = leg_len;
            end
        end
        if (walk_ended) begin
            beat.finished = 1'b1;
            return beat;
        end
        if (!origin) begin
            case (walk_dir)
                usp_pkg::HEAD_RIGHT: walk_x = walk_x + usp_pkg::COORD_BITS'(1);
                usp_pkg::HEAD_UP:    walk_y = walk_y + usp_pkg::COORD_BITS'(1);
                usp_pkg::HEAD_LEFT:  walk_x = walk_x - usp_pkg::COORD_BITS'(1);
                default:             walk_y = walk_y - usp_pkg::COORD_BITS'(1);
            endcase
            steps_rem = steps_rem - usp_pkg::COORD_BITS'(1);
            if (steps_rem == '0) walk_dir = walk_dir + 2'd1;
        end
        beat.x = walk_x;
        beat.y = walk_y;
        beat.number = number_next;
        beat.prime = trial_prime(number_next);
        number_next = number_next + usp_pkg::NUMBER_BITS'(1);
        return beat;
    endfunction

    function automatic t_plan_row walk_row(input logic rs);
        t_plan_row r;
        r.kind = ROW_CELL;
        r.index = '0;
        r.data = '0;
        r.restart = rs;
        r.typed = 1'b0;
        r.beat = '0;
        return r;
    endfunction

    function automatic t_plan_row known_row(input logic rs, input int x, input int y,
                                            input int num, input bit p, input bit f);
        t_plan_row r;
        r = walk_row(rs);
        r.typed = 1'b1;
        r.beat.x = usp_pkg::COORD_BITS'(x);
        r.beat.y = usp_pkg::COORD_BITS'(y);
        r.beat.number = usp_pkg::NUMBER_BITS'(num);
        r.beat.prime = p;
        r.beat.finished = f;
        return r;
    endfunction

    function automatic t_plan_row write_row(input logic [usp_pkg::CFG_IDX_BITS-1:0] idx,
                                            input logic [usp_pkg::LIMIT_BITS-1:0] data);
        t_plan_row r;
        r = walk_row(1'b0);
        r.kind = ROW_WRITE;
        r.index = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [usp_pkg::LIMIT_BITS-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:          return '0;
            1, 2, 3, 4: return usp_pkg::LIMIT_BITS'($urandom_range(1, 6));
            5:          return '1;
            default:    return usp_pkg::LIMIT_BITS'($urandom_range(1, 511));
        endcase
    endfunction

    // called at a rising edge; returns at the edge that took the beat
    task automatic feed_cell(input logic rs, input bit typed, input t_cell_beat known);
        int gap;
        t_cell_beat beat;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_restart <= rs;
        do @(posedge i_clk); while (o_in_stall);
        beat = spiral_next_cell(rs);
        pending_cells.push_back(typed ? known : beat);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [usp_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [usp_pkg::LIMIT_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == usp_pkg::REG_X_LIMIT) lim_x = data;
        else if (idx == usp_pkg::REG_Y_LIMIT) lim_y = data;
    endtask

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == '0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick[3:0] > 4'd5);
        endcase
    end

    always @(posedge i_clk) begin
        t_cell_beat got;
        t_cell_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_cell_x, o_cell_y, o_cell_number, o_is_prime, o_finished};
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: x=%0d y=%0d n=%0d p=%0b f=%0b",
                             got.x, got.y, got.number, got.prime, got.finished);
            end else begin
                want = pending_cells.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: exp x=%0d y=%0d n=%0d p=%0b f=%0b,",
                                 want.x, want.y, want.number, want.prime, want.finished,
                                 " got x=%0d y=%0d n=%0d p=%0b f=%0b",
                                 got.x, got.y, got.number, got.prime, got.finished);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int   sent;
        int   run;
        bit   lead_restart;
        logic rs;

        // after reset, limits at reset value
        plan.push_back(known_row(1'b0, 0, 0, 1, 1'b0, 1'b0));
        plan.push_back(known_row(1'b0, 1, 0, 2, 1'b1, 1'b0));
        plan.push_back(known_row(1'b0, 1, 1, 3, 1'b1, 1'b0));
        plan.push_back(known_row(1'b0, 0, 1, 4, 1'b0, 1'b0));
        plan.push_back(known_row(1'b0, -1, 1, 5, 1'b1, 1'b0));
        repeat (4) plan.push_back(walk_row(1'b0));
        plan.push_back(known_row(1'b1, 0, 0, 1, 1'b0, 1'b0));
        plan.push_back(known_row(1'b1, 0, 0, 1, 1'b0, 1'b0));
        plan.push_back(known_row(1'b0, 1, 0, 2, 1'b1, 1'b0));
        // limits of one: walk ends after three cells
        plan.push_back(write_row(usp_pkg::REG_X_LIMIT, usp_pkg::LIMIT_BITS'(1)));
        plan.push_back(write_row(usp_pkg::REG_Y_LIMIT, usp_pkg::LIMIT_BITS'(1)));
        plan.push_back(known_row(1'b1, 0, 0, 1, 1'b0, 1'b0));
        repeat (2) plan.push_back(walk_row(1'b0));
        plan.push_back(known_row(1'b0, 0, 0, 0, 1'b0, 1'b1));
        plan.push_back(known_row(1'b0, 0, 0, 0, 1'b0, 1'b1));
        // vertical limit at max, horizontal still ends the walk
        plan.push_back(write_row(usp_pkg::REG_Y_LIMIT, '1));
        plan.push_back(walk_row(1'b1));
        repeat (3) plan.push_back(walk_row(1'b0));
        // zero limit: no cell at all
        plan.push_back(write_row(usp_pkg::REG_X_LIMIT, '0));
        plan.push_back(known_row(1'b1, 0, 0, 0, 1'b0, 1'b1));
        plan.push_back(write_row(REG_SPARE_2, usp_pkg::LIMIT_BITS'(9'h155)));
        plan.push_back(write_row(REG_SPARE_3, usp_pkg::LIMIT_BITS'(9'h0AA)));
        plan.push_back(write_row(usp_pkg::REG_Y_LIMIT, '0));
        plan.push_back(write_row(usp_pkg::REG_X_LIMIT, '1));
        plan.push_back(walk_row(1'b1));
        repeat (2) plan.push_back(walk_row(1'b0));
        plan.push_back(write_row(usp_pkg::REG_Y_LIMIT, '1));
        plan.push_back(walk_row(1'b1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[i].index, plan[i].data);
            end else begin
                feed_cell(plan[i].restart, plan[i].typed, plan[i].beat);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            write_reg(usp_pkg::REG_X_LIMIT, pick_limit());
            settle();
            write_reg(usp_pkg::REG_Y_LIMIT, pick_limit());
            run = $urandom_range(12, 30);
            lead_restart = 1'($urandom_range(0, 1));
            for (int k = 0; k < run && sent < RANDOM_ITEMS; k++) begin
                rs = (k == 0 && lead_restart) || ($urandom_range(0, 9) == 0);
                feed_cell(rs, 1'b0, '0);
                sent++;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
